// ===== hdl/gvol_pkg.sv =====
`default_nettype none
package gvol_pkg;

	localparam int X_W         = 8;
	localparam int Y_W         = 8;
	localparam int Z_W         = 12;
	localparam int ADDR_W      = X_W + Y_W;
	localparam int PLANE_WORDS = 1 << ADDR_W;
	localparam int SAMPLE_W    = 16;
	localparam int GRAD_W      = 18;
	localparam int XS_W        = 9;
	localparam int ZS_W        = 13;
	localparam int CFG_W       = 13;
	localparam int IDX_W       = 2;
	localparam int RAM_COPIES  = 3;
	localparam int RD_PORTS    = 2 * RAM_COPIES;

	localparam logic [IDX_W-1:0] REG_X_SIZE = 2'd0;
	localparam logic [IDX_W-1:0] REG_Y_SIZE = 2'd1;
	localparam logic [IDX_W-1:0] REG_Z_SIZE = 2'd2;

	localparam logic [XS_W-1:0] MIN_XY  = 9'd2;
	localparam logic [XS_W-1:0] MAX_X   = 9'd256;
	localparam logic [XS_W-1:0] MAX_Y   = 9'd256;
	localparam logic [ZS_W-1:0] MIN_Z   = 13'd2;
	localparam logic [ZS_W-1:0] Z_LIMIT = 13'd4096;
	localparam logic [XS_W-1:0] RESET_XY = 9'd256;
	localparam logic [ZS_W-1:0] RESET_Z  = 13'd256;

	// Both queues hold four entries.
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_CNT_W = 3;

	typedef enum logic [1:0] {
		MODE_FIRST,
		MODE_MID,
		MODE_DRAIN
	} mode_t;

	typedef struct packed {
		logic [XS_W-1:0] ex;
		logic [XS_W-1:0] ey;
		logic [ZS_W-1:0] ez;
	} dims_t;

	typedef struct packed {
		logic                       emit;
		logic                       wr;
		logic                       par;
		mode_t                      mode;
		logic [X_W-1:0]             x;
		logic [Y_W-1:0]             y;
		logic                       xb0;
		logic                       xbe;
		logic                       yb0;
		logic                       ybe;
		logic                       last;
		logic signed [SAMPLE_W-1:0] sample;
	} job_t;

	typedef struct packed {
		logic signed [GRAD_W-1:0] gx;
		logic signed [GRAD_W-1:0] gy;
		logic signed [GRAD_W-1:0] gz;
		logic                     last;
	} res_t;

endpackage
`default_nettype wire

// ===== hdl/gvol_ram.sv =====
`default_nettype none
module gvol_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 65536,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr_a,
	input  wire logic [AW-1:0]    raddr_b,
	output logic      [WIDTH-1:0] rdata_a,
	output logic      [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read at the address being written returns the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
`default_nettype wire

// ===== hdl/gvol_front.sv =====
`default_nettype none
module gvol_front (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire gvol_pkg::dims_t                     dims,
	input  wire logic                                restart,
	input  wire logic                                push,
	output logic                                     full,
	input  wire logic signed [gvol_pkg::SAMPLE_W-1:0] sample,
	input  wire logic                                flush,
	output logic                                     job_valid,
	output gvol_pkg::job_t                           job,
	input  wire logic                                job_pop
);

	logic [gvol_pkg::X_W-1:0] in_x_q, out_x_q;
	logic [gvol_pkg::Y_W-1:0] in_y_q, out_y_q;
	logic [gvol_pkg::Z_W-1:0] in_z_q;
	logic                     drain_q;

	gvol_pkg::job_t           q_mem [gvol_pkg::Q_DEPTH];
	logic [gvol_pkg::Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [gvol_pkg::Q_CNT_W-1:0] cnt_q;

	logic accept, enq;
	logic ix_end, iy_end, iz_end, ox_end, oy_end;
	gvol_pkg::job_t new_job;

	assign full      = (cnt_q == gvol_pkg::Q_CNT_W'(gvol_pkg::Q_DEPTH));
	assign job_valid = (cnt_q != '0);
	assign job       = q_mem[rd_ptr_q];
	assign accept    = push & ~full;

	assign ix_end = ({1'b0, in_x_q} + 9'd1) >= dims.ex;
	assign iy_end = ({1'b0, in_y_q} + 9'd1) >= dims.ey;
	assign iz_end = ({1'b0, in_z_q} + 13'd1) >= dims.ez;
	assign ox_end = ({1'b0, out_x_q} + 9'd1) >= dims.ex;
	assign oy_end = ({1'b0, out_y_q} + 9'd1) >= dims.ey;

	// Classify the transaction into a job for the back end.
	always_comb begin
		new_job = '0;
		if (drain_q) begin
			new_job.emit = 1'b1;
			new_job.par  = ~dims.ez[0];
			new_job.mode = gvol_pkg::MODE_DRAIN;
			new_job.x    = out_x_q;
			new_job.y    = out_y_q;
			new_job.xbe  = ox_end;
			new_job.ybe  = oy_end;
			new_job.last = ox_end & oy_end;
			enq          = accept & flush;
		end else begin
			new_job.emit   = (in_z_q != '0);
			new_job.wr     = 1'b1;
			new_job.par    = ~in_z_q[0];
			new_job.mode   = (in_z_q == 12'd1) ? gvol_pkg::MODE_FIRST : gvol_pkg::MODE_MID;
			new_job.x      = in_x_q;
			new_job.y      = in_y_q;
			new_job.xbe    = ix_end;
			new_job.ybe    = iy_end;
			new_job.sample = sample;
			enq            = accept & ~flush;
		end
		new_job.xb0 = (new_job.x == '0);
		new_job.yb0 = (new_job.y == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_x_q  <= '0;
			in_y_q  <= '0;
			in_z_q  <= '0;
			out_x_q <= '0;
			out_y_q <= '0;
			drain_q <= 1'b0;
		end else if (restart) begin
			in_x_q  <= '0;
			in_y_q  <= '0;
			in_z_q  <= '0;
			out_x_q <= '0;
			out_y_q <= '0;
			drain_q <= 1'b0;
		end else if (enq) begin
			if (drain_q) begin
				if (ox_end && oy_end) begin
					out_x_q <= '0;
					out_y_q <= '0;
					drain_q <= 1'b0;
				end else if (ox_end) begin
					out_x_q <= '0;
					out_y_q <= out_y_q + 8'd1;
				end else begin
					out_x_q <= out_x_q + 8'd1;
				end
			end else if (!ix_end) begin
				in_x_q <= in_x_q + 8'd1;
			end else begin
				in_x_q <= '0;
				if (!iy_end) begin
					in_y_q <= in_y_q + 8'd1;
				end else begin
					in_y_q <= '0;
					if (!iz_end) begin
						in_z_q <= in_z_q + 12'd1;
					end else begin
						in_z_q  <= '0;
						drain_q <= 1'b1;
						out_x_q <= '0;
						out_y_q <= '0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (enq) begin
				wr_ptr_q <= wr_ptr_q + 2'd1;
			end
			if (job_pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			case ({enq, job_pop})
				2'b10:   cnt_q <= cnt_q + 3'd1;
				2'b01:   cnt_q <= cnt_q - 3'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (enq) begin
			q_mem[wr_ptr_q] <= new_job;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= gvol_pkg::Q_CNT_W'(gvol_pkg::Q_DEPTH))
		else $error("job queue count out of range");
	a_drain_pos: assert property (@(posedge clk) disable iff (!arst_n)
		drain_q |-> (in_x_q == '0 && in_y_q == '0 && in_z_q == '0))
		else $error("input position not cleared while draining");
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		restart |=> (!drain_q && in_z_q == '0 && out_y_q == '0))
		else $error("restart did not clear positions");

endmodule
`default_nettype wire

// ===== hdl/gvol_back.sv =====
`default_nettype none
module gvol_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           job_valid,
	input  wire gvol_pkg::job_t job,
	output logic                job_pop,
	output logic                empty,
	input  wire logic           pop,
	output gvol_pkg::res_t      res
);

	function automatic logic signed [gvol_pkg::GRAD_W-1:0] grad_diff(
		input logic signed [gvol_pkg::SAMPLE_W-1:0] p,
		input logic signed [gvol_pkg::SAMPLE_W-1:0] c,
		input logic signed [gvol_pkg::SAMPLE_W-1:0] n,
		input logic b0,
		input logic be
	);
		logic signed [gvol_pkg::GRAD_W-1:0] pe, ce, ne;
		pe = gvol_pkg::GRAD_W'(p);
		ce = gvol_pkg::GRAD_W'(c);
		ne = gvol_pkg::GRAD_W'(n);
		if (b0) begin
			return (ne - ce) <<< 1;
		end else if (be) begin
			return (ce - pe) <<< 1;
		end
		return ne - pe;
	endfunction

	logic [gvol_pkg::ADDR_W-1:0]   raddr [gvol_pkg::RD_PORTS];
	logic [gvol_pkg::SAMPLE_W-1:0] rd [2][gvol_pkg::RD_PORTS];
	logic [1:0]                    we;

	logic           v_s1_q;
	gvol_pkg::job_t job_s1;

	gvol_pkg::res_t               oq [gvol_pkg::Q_DEPTH];
	logic [gvol_pkg::Q_PTR_W-1:0] owr_ptr_q, ord_ptr_q;
	logic [gvol_pkg::Q_CNT_W-1:0] ocnt_q;
	logic [gvol_pkg::Q_CNT_W-1:0] committed;
	logic                         oenq, odeq;

	logic signed [gvol_pkg::SAMPLE_W-1:0] vc, vl, vr, vu, vd, vp;
	logic signed [gvol_pkg::GRAD_W-1:0]   s_e, c_e, p_e;
	gvol_pkg::res_t                       new_res;

	// Only issue when the result queue has room for everything in flight.
	assign committed = ocnt_q + {2'b0, v_s1_q & job_s1.emit};
	assign job_pop   = job_valid && (committed < gvol_pkg::Q_CNT_W'(gvol_pkg::Q_DEPTH));

	assign raddr[0] = {job.y, job.x};
	assign raddr[1] = {job.y, job.x - 8'd1};
	assign raddr[2] = {job.y, job.x + 8'd1};
	assign raddr[3] = {job.y - 8'd1, job.x};
	assign raddr[4] = {job.y + 8'd1, job.x};
	assign raddr[5] = {job.y, job.x};

	for (genvar p = 0; p < 2; p++) begin : g_par
		assign we[p] = job_pop & job.wr & (job.par != 1'(p));
		for (genvar k = 0; k < gvol_pkg::RAM_COPIES; k++) begin : g_copy
			gvol_ram #(
				.WIDTH(gvol_pkg::SAMPLE_W),
				.DEPTH(gvol_pkg::PLANE_WORDS)
			) u_ram (
				.clk    (clk),
				.we     (we[p]),
				.waddr  (raddr[0]),
				.wdata  (job.sample),
				.raddr_a(raddr[2*k]),
				.raddr_b(raddr[2*k+1]),
				.rdata_a(rd[p][2*k]),
				.rdata_b(rd[p][2*k+1])
			);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q <= 1'b0;
		end else begin
			v_s1_q <= job_pop;
		end
	end

	always_ff @(posedge clk) begin
		if (job_pop) begin
			job_s1 <= job;
		end
	end

	always_comb begin
		vc = rd[job_s1.par][0];
		vl = rd[job_s1.par][1];
		vr = rd[job_s1.par][2];
		vu = rd[job_s1.par][3];
		vd = rd[job_s1.par][4];
		vp = rd[~job_s1.par][5];
		s_e = gvol_pkg::GRAD_W'(job_s1.sample);
		c_e = gvol_pkg::GRAD_W'(vc);
		p_e = gvol_pkg::GRAD_W'(vp);
		new_res.gx   = grad_diff(vl, vc, vr, job_s1.xb0, job_s1.xbe);
		new_res.gy   = grad_diff(vu, vc, vd, job_s1.yb0, job_s1.ybe);
		new_res.last = job_s1.last;
		case (job_s1.mode)
			gvol_pkg::MODE_FIRST: new_res.gz = (s_e - c_e) <<< 1;
			gvol_pkg::MODE_MID:   new_res.gz = s_e - p_e;
			gvol_pkg::MODE_DRAIN: new_res.gz = (c_e - p_e) <<< 1;
			default:              new_res.gz = '0;
		endcase
	end

	assign oenq  = v_s1_q & job_s1.emit;
	assign empty = (ocnt_q == '0);
	assign odeq  = pop & ~empty;
	assign res   = oq[ord_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_ptr_q <= '0;
			ord_ptr_q <= '0;
			ocnt_q    <= '0;
		end else begin
			if (oenq) begin
				owr_ptr_q <= owr_ptr_q + 2'd1;
			end
			if (odeq) begin
				ord_ptr_q <= ord_ptr_q + 2'd1;
			end
			case ({oenq, odeq})
				2'b10:   ocnt_q <= ocnt_q + 3'd1;
				2'b01:   ocnt_q <= ocnt_q - 3'd1;
				default: ocnt_q <= ocnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (oenq) begin
			oq[owr_ptr_q] <= new_res;
		end
	end

	a_ocnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q <= gvol_pkg::Q_CNT_W'(gvol_pkg::Q_DEPTH))
		else $error("result queue count out of range");
	a_pop_valid: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> job_valid)
		else $error("job taken from an empty queue");
	a_room: assert property (@(posedge clk) disable iff (!arst_n)
		oenq |-> (ocnt_q < gvol_pkg::Q_CNT_W'(gvol_pkg::Q_DEPTH)))
		else $error("result written into a full queue");

endmodule
`default_nettype wire

// ===== hdl/volume_gradient_3d_core.sv =====
`default_nettype none
// Streaming 3D central-difference gradient. Voxels enter in raster order (x fastest)
// through push/full; each transaction with flush low carries one voxel. Results leave
// through empty/pop, one per voxel, holding the x, y and z derivatives in half-LSB units
// (interior points use next minus previous, borders twice the one-sided difference).
// Results lag the input by one plane: the first plane gives none, and after the last
// voxel one flush transaction per voxel drains the final plane; its last result has
// last set, after which a new volume may start. Flush transactions while voxels are
// expected, and voxels sent while draining, are taken and discarded. One transaction is
// accepted per clock cycle unless full is set; results pass the job queue, RAM read
// register and result queue. The front end tracks the stream position and queues jobs;
// the back end reads two 64K-voxel plane stores, each held as three dual-read copies so
// a voxel, its four in-plane neighbors and the previous plane's voxel are read together.
// Writing a size register restarts the stream; sizes are clamped to 2..256 (x, y) and
// 2..4096 (z). Write them only while the block is idle; the block does not enforce this.
module volume_gradient_3d_core (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  push,
	output logic                                       full,
	input  wire logic signed [gvol_pkg::SAMPLE_W-1:0]  sample,
	input  wire logic                                  flush,
	output logic                                       empty,
	input  wire logic                                  pop,
	output logic signed [gvol_pkg::GRAD_W-1:0]         grad_x,
	output logic signed [gvol_pkg::GRAD_W-1:0]         grad_y,
	output logic signed [gvol_pkg::GRAD_W-1:0]         grad_z,
	output logic                                       last,
	input  wire logic                                  cfg_we,
	input  wire logic [gvol_pkg::IDX_W-1:0]            cfg_index,
	input  wire logic [gvol_pkg::CFG_W-1:0]            cfg_data
);

	logic [gvol_pkg::XS_W-1:0] x_size_q, y_size_q;
	logic [gvol_pkg::ZS_W-1:0] z_size_q;
	logic                      restart;
	gvol_pkg::dims_t           dims;
	logic                      job_valid, job_pop;
	gvol_pkg::job_t            job;
	gvol_pkg::res_t            res;

	// Any write to a defined register restarts the stream in the same cycle.
	assign restart = cfg_we && (cfg_index == gvol_pkg::REG_X_SIZE ||
		cfg_index == gvol_pkg::REG_Y_SIZE || cfg_index == gvol_pkg::REG_Z_SIZE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_size_q <= gvol_pkg::RESET_XY;
			y_size_q <= gvol_pkg::RESET_XY;
			z_size_q <= gvol_pkg::RESET_Z;
		end else if (cfg_we) begin
			case (cfg_index)
				gvol_pkg::REG_X_SIZE: x_size_q <= cfg_data[gvol_pkg::XS_W-1:0];
				gvol_pkg::REG_Y_SIZE: y_size_q <= cfg_data[gvol_pkg::XS_W-1:0];
				gvol_pkg::REG_Z_SIZE: z_size_q <= cfg_data;
				default:              ;
			endcase
		end
	end

	// Effective sizes after clamping to the supported range.
	always_comb begin
		dims.ex = (x_size_q < gvol_pkg::MIN_XY) ? gvol_pkg::MIN_XY :
			(x_size_q > gvol_pkg::MAX_X) ? gvol_pkg::MAX_X : x_size_q;
		dims.ey = (y_size_q < gvol_pkg::MIN_XY) ? gvol_pkg::MIN_XY :
			(y_size_q > gvol_pkg::MAX_Y) ? gvol_pkg::MAX_Y : y_size_q;
		dims.ez = (z_size_q < gvol_pkg::MIN_Z) ? gvol_pkg::MIN_Z :
			(z_size_q > gvol_pkg::Z_LIMIT) ? gvol_pkg::Z_LIMIT : z_size_q;
	end

	gvol_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.dims     (dims),
		.restart  (restart),
		.push     (push),
		.full     (full),
		.sample   (sample),
		.flush    (flush),
		.job_valid(job_valid),
		.job      (job),
		.job_pop  (job_pop)
	);

	gvol_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.job_valid(job_valid),
		.job      (job),
		.job_pop  (job_pop),
		.empty    (empty),
		.pop      (pop),
		.res      (res)
	);

	assign grad_x = res.gx;
	assign grad_y = res.gy;
	assign grad_z = res.gz;
	assign last   = res.last;

endmodule
`default_nettype wire

// ===== bench/volume_gradient_3d_core_tb.sv =====
`default_nettype none
module volume_gradient_3d_core_tb;

	// A cycle with no transaction on either side counts toward this limit.
	localparam int QUIET_LIMIT = 5000;
	// Cycles allowed for the pipeline to settle before a register write or the end.
	localparam int SETTLE = 24;
	// Register index that maps to no register.
	localparam logic [gvol_pkg::IDX_W-1:0] REG_NONE = 2'd3;
	// Voxel count that never cuts a volume short.
	localparam int NO_CAP = 1 << 30;
	// Input transactions to send in total, directed part included.
	localparam int ITEM_TARGET = 620;

	logic                                 clk = 1'b0;
	logic                                 arst_n = 1'b0;
	logic                                 push = 1'b0;
	logic                                 full;
	logic signed [gvol_pkg::SAMPLE_W-1:0] sample = '0;
	logic                                 flush = 1'b0;
	logic                                 empty;
	logic                                 pop = 1'b0;
	logic signed [gvol_pkg::GRAD_W-1:0]   grad_x, grad_y, grad_z;
	logic                                 last;
	logic                                 cfg_we = 1'b0;
	logic [gvol_pkg::IDX_W-1:0]           cfg_index = gvol_pkg::REG_X_SIZE;
	logic [gvol_pkg::CFG_W-1:0]           cfg_data = '0;

	volume_gradient_3d_core dut (
		.clk(clk), .arst_n(arst_n),
		.push(push), .full(full), .sample(sample), .flush(flush),
		.empty(empty), .pop(pop),
		.grad_x(grad_x), .grad_y(grad_y), .grad_z(grad_z), .last(last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// One row of the directed table. When typed is set and the row gives a result,
	// the hand-computed gradients below replace the predicted ones.
	typedef struct {
		logic signed [gvol_pkg::SAMPLE_W-1:0] s;
		logic                                 f;
		bit                                   typed;
		int                                   gx, gy, gz;
		bit                                   lst;
	} vox_row_t;

	gvol_pkg::res_t grad_q [$];      // gradients still owed by the block, oldest first
	int   errs = 0;
	int   quiet = 0;
	int   sent = 0;        // input transactions accepted so far
	bit   steady = 0;      // when set, neither side idles

	// Shadow copy of the block's registers, positions and plane stores.
	logic [gvol_pkg::XS_W-1:0]            x_reg, y_reg;
	logic [gvol_pkg::ZS_W-1:0]            z_reg;
	int                                   ex, ey, ez;
	int                                   ix, iy, iz, ox, oy;
	bit                                   draining;
	logic signed [gvol_pkg::SAMPLE_W-1:0] planes [0:2*gvol_pkg::PLANE_WORDS-1];

	function automatic int clampi(int v, int lo, int hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic void resync();
		ex = clampi(x_reg, 2, 256);
		ey = clampi(y_reg, 2, 256);
		ez = clampi(z_reg, 2, 4096);
		ix = 0; iy = 0; iz = 0; ox = 0; oy = 0;
		draining = 0;
	endfunction

	function automatic int voxel(int z, int x, int y);
		return planes[(z & 1) * gvol_pkg::PLANE_WORDS + y * 256 + x];
	endfunction

	// Twice the one-sided difference at a border, next minus previous inside.
	function automatic int slope(int c, int n, int prv, int cur, int nxt);
		if (c == 0) return 2 * (nxt - cur);
		if (c + 1 >= n) return 2 * (cur - prv);
		return nxt - prv;
	endfunction

	function automatic gvol_pkg::res_t gradients(int x, int y, int zo, int zg, bit lst);
		gvol_pkg::res_t r;
		int c, lf, rt, up, dn;
		c  = voxel(zo, x, y);
		lf = x > 0 ? voxel(zo, x - 1, y) : 0;
		rt = x + 1 < ex ? voxel(zo, x + 1, y) : 0;
		up = y > 0 ? voxel(zo, x, y - 1) : 0;
		dn = y + 1 < ey ? voxel(zo, x, y + 1) : 0;
		r.gx = gvol_pkg::GRAD_W'(slope(x, ex, lf, c, rt));
		r.gy = gvol_pkg::GRAD_W'(slope(y, ey, up, c, dn));
		r.gz = gvol_pkg::GRAD_W'(zg);
		r.last = lst;
		return r;
	endfunction

	// Advances the shadow state by one accepted transaction.
	task automatic predict_gradients(input logic signed [gvol_pkg::SAMPLE_W-1:0] s,
			input logic f, output bit got, output gvol_pkg::res_t r);
		int zo, zg;
		bit lst;
		got = 0;
		r = '0;
		if (draining) begin
			// Samples sent while the last plane drains are dropped.
			if (!f) return;
			zo = ez - 1;
			lst = (ox + 1 >= ex) && (oy + 1 >= ey);
			zg = 2 * (voxel(zo, ox, oy) - voxel(zo - 1, ox, oy));
			r = gradients(ox, oy, zo, zg, lst);
			got = 1;
			if (lst) begin
				resync();
			end else if (++ox >= ex) begin
				ox = 0;
				oy++;
			end
			return;
		end
		// A flush while voxels are still expected does nothing.
		if (f) return;
		if (iz >= 1) begin
			zo = iz - 1;
			// The second plane sees only one plane behind it; later planes use both sides.
			zg = (zo == 0) ? 2 * (s - voxel(0, ix, iy)) : s - voxel(iz, ix, iy);
			r = gradients(ix, iy, zo, zg, 1'b0);
			got = 1;
		end
		planes[(iz & 1) * gvol_pkg::PLANE_WORDS + iy * 256 + ix] = s;
		if (++ix >= ex) begin
			ix = 0;
			if (++iy >= ey) begin
				iy = 0;
				if (++iz >= ez) begin
					iz = 0;
					draining = 1;
					ox = 0;
					oy = 0;
				end
			end
		end
	endtask

	// Offers one transaction and returns at the edge that accepts it. Push is left
	// high so that back-to-back transactions need no extra assignment.
	task automatic send(input logic signed [gvol_pkg::SAMPLE_W-1:0] s, input logic f,
			output bit got, output gvol_pkg::res_t r);
		if (!steady && $urandom_range(99) < 7) begin
			push <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		push <= 1'b1;
		sample <= s;
		flush <= f;
		do @(posedge clk); while (full);
		sent++;
		predict_gradients(s, f, got, r);
	endtask

	task automatic send_checked(input logic signed [gvol_pkg::SAMPLE_W-1:0] s,
			input logic f);
		bit got;
		gvol_pkg::res_t r;
		send(s, f, got, r);
		if (got) grad_q.push_back(r);
	endtask

	// Waits until every owed result is out and the pipeline has had time to settle.
	task automatic drain_to_idle();
		push <= 1'b0;
		while (grad_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input logic [gvol_pkg::IDX_W-1:0] idx, input int value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value[gvol_pkg::CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			gvol_pkg::REG_X_SIZE: x_reg = value[gvol_pkg::XS_W-1:0];
			gvol_pkg::REG_Y_SIZE: y_reg = value[gvol_pkg::XS_W-1:0];
			gvol_pkg::REG_Z_SIZE: z_reg = value[gvol_pkg::ZS_W-1:0];
			default: return;
		endcase
		resync();
	endtask

	task automatic set_sizes(input int xs, input int ys, input int zs);
		drain_to_idle();
		write_reg(gvol_pkg::REG_X_SIZE, xs);
		write_reg(gvol_pkg::REG_Y_SIZE, ys);
		write_reg(gvol_pkg::REG_Z_SIZE, zs);
	endtask

	// Streams one volume with random voxels, then drains its last plane. A few
	// stray transactions are mixed in; an abandoned volume stops partway through,
	// and no more than cap voxels are sent.
	task automatic run_volume(input bit abandon, input int cap);
		int total, cut;
		total = ex * ey * ez;
		cut = abandon ? $urandom_range(total - 1, 1) : total;
		if (cut > cap) cut = cap;
		for (int i = 0; i < cut; i++) begin
			if ($urandom_range(99) < 4) send_checked(gvol_pkg::SAMPLE_W'($urandom), 1'b1);
			send_checked(gvol_pkg::SAMPLE_W'($urandom), 1'b0);
		end
		if (cut < total) return;
		for (int i = 0; i < ex * ey; i++) begin
			if ($urandom_range(99) < 4) send_checked(gvol_pkg::SAMPLE_W'($urandom), 1'b0);
			send_checked(gvol_pkg::SAMPLE_W'($urandom), 1'b1);
		end
	endtask

	// Result side: checks each accepted result, keeps the watchdog, and pops at random.
	always @(posedge clk) begin
		gvol_pkg::res_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (grad_q.size() == 0) begin
					$error("result with no expectation: gx=%0d gy=%0d gz=%0d last=%0b",
						grad_x, grad_y, grad_z, last);
					errs++;
				end else begin
					want = grad_q.pop_front();
					if (grad_x !== want.gx) begin
						$error("grad_x: expected %0d, got %0d", want.gx, grad_x);
						errs++;
					end
					if (grad_y !== want.gy) begin
						$error("grad_y: expected %0d, got %0d", want.gy, grad_y);
						errs++;
					end
					if (grad_z !== want.gz) begin
						$error("grad_z: expected %0d, got %0d", want.gz, grad_z);
						errs++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, got %0b", want.last, last);
						errs++;
					end
				end
			end
			if ((push && !full) || (pop && !empty)) quiet <= 0;
			else quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("Test completed with failures");
				$finish;
			end
			pop <= steady || ($urandom_range(99) >= 7);
		end
	end

	initial begin
		vox_row_t dir_tab [0:14];
		bit   got;
		gvol_pkg::res_t r;

		// A 2x2x2 volume with full-scale voxels. Every gradient is small enough to
		// work out by hand. Stray transactions sit at the start, between planes and
		// in the middle of the drain.
		dir_tab = '{
			'{16'sh1234, 1'b1, 1, 0, 0, 0, 0},                  // flush before any voxel
			'{16'sh7FFF, 1'b0, 1, 0, 0, 0, 0},                  // first plane: no results
			'{16'sh8000, 1'b0, 1, 0, 0, 0, 0},
			'{16'sh0000, 1'b0, 1, 0, 0, 0, 0},
			'{16'shFFFF, 1'b0, 1, 0, 0, 0, 0},
			'{16'sh5555, 1'b1, 1, 0, 0, 0, 0},                  // flush between planes
			'{16'sh8000, 1'b0, 1, -131070, -65534, -131070, 0}, // second plane
			'{16'sh7FFF, 1'b0, 1, -131070, 65534, 131070, 0},
			'{16'sh0005, 1'b0, 1, -2, -65534, 10, 0},
			'{16'sh0000, 1'b0, 1, -2, 65534, 2, 0},
			'{16'shAAAA, 1'b1, 1, 131070, 65546, -131070, 0},   // drain of the last plane
			'{16'sh0F0F, 1'b0, 1, 0, 0, 0, 0},                  // voxel while draining
			'{16'sh0000, 1'b1, 1, 131070, -65534, 131070, 0},
			'{16'sh0000, 1'b1, 1, -10, 65546, 10, 0},
			'{16'sh0000, 1'b1, 1, -10, -65534, 2, 1}
		};

		x_reg = gvol_pkg::RESET_XY;
		y_reg = gvol_pkg::RESET_XY;
		z_reg = gvol_pkg::RESET_Z;
		resync();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sizes below the minimum are clamped to two.
		write_reg(gvol_pkg::REG_X_SIZE, 0);
		write_reg(gvol_pkg::REG_Y_SIZE, 1);
		write_reg(gvol_pkg::REG_Z_SIZE, 0);
		foreach (dir_tab[i]) begin
			send(dir_tab[i].s, dir_tab[i].f, got, r);
			if (got) begin
				if (dir_tab[i].typed) begin
					r.gx = gvol_pkg::GRAD_W'(dir_tab[i].gx);
					r.gy = gvol_pkg::GRAD_W'(dir_tab[i].gy);
					r.gz = gvol_pkg::GRAD_W'(dir_tab[i].gz);
					r.last = dir_tab[i].lst;
				end
				grad_q.push_back(r);
			end
		end

		// The unused register index must leave the stream alone.
		drain_to_idle();
		write_reg(REG_NONE, 13'h1FFF);

		// Extreme sizes: an over-range x that clamps to the widest row, streamed with
		// no idling into the second plane, then a deep volume that clamps z.
		steady = 1;
		set_sizes(511, 2, 2);
		run_volume(0, 516);
		steady = 0;
		set_sizes(2, 2, 5000);
		run_volume(0, 24);

		// Small random volumes, now and then abandoned partway by a size change.
		while (sent < ITEM_TARGET) begin
			set_sizes($urandom_range(9) < 1 ? $urandom_range(1, 0) : $urandom_range(9, 2),
				$urandom_range(6, 2), $urandom_range(5, 2));
			repeat ($urandom_range(2, 1)) run_volume($urandom_range(7) == 0, NO_CAP);
		end

		drain_to_idle();
		if (errs == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
`default_nettype wire
